// ===== rtl/core/timm_pkg.sv =====
// shared constants, types and helpers for the tiled int8 matrix multiply engine
package timm_pkg;

  // matrix geometry
  localparam int MATRIX_SIZE = 16;
  localparam int TILE_SIZE   = 8;
  localparam int CELLS       = MATRIX_SIZE * MATRIX_SIZE;
  localparam int CELL_W      = $clog2(CELLS);
  localparam int CNT_W       = $clog2(MATRIX_SIZE + TILE_SIZE + 1);

  // operand and result widths
  localparam int ELEM_W = 8;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 32;

  // command codes
  typedef enum logic [1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_READ_C  = 2'd3
  } command_t;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CELL_W-1:0] cell_t;

  // linear store address of an element
  function automatic cell_t cell_addr(input int unsigned r, input int unsigned c);
    int unsigned lin;
    lin = r * MATRIX_SIZE + c;
    return CELL_W'(lin);
  endfunction

  // exclusive end of a tile, cut at the matrix edge
  function automatic cnt_t tile_end(input cnt_t origin);
    int unsigned e;
    e = int'(origin) + TILE_SIZE;
    if (e > MATRIX_SIZE) begin
      e = MATRIX_SIZE;
    end
    return CNT_W'(e);
  endfunction

endpackage

// ===== rtl/core/timm_cmd_if.sv =====
// command channel: valid/ready handshake with the command payload
interface timm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] row;
  logic [3:0] col;
  logic [7:0] element_value;

  modport source (output valid, output command, output row, output col,
                  output element_value, input ready);
  modport sink   (input valid, input command, input row, input col,
                  input element_value, output ready);
endinterface

// ===== rtl/core/timm_rsp_if.sv =====
// result channel: valid/ready handshake with the read-back payload
interface timm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] product_value;
  logic [3:0]  out_row;
  logic [3:0]  out_col;

  modport source (output valid, output product_value, output out_row, output out_col,
                  input ready);
  modport sink   (input valid, input product_value, input out_row, input out_col,
                  output ready);
endinterface

// ===== rtl/core/timm_ram.sv =====
// generic simple dual-port ram with registered read
module timm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/tiled_int8_matrix_multiply_top.sv =====
// top level of the tiled int8 matrix multiply engine
//
// Channels: in_ch carries commands (write A element, write B element, compute,
// read C element); out_ch returns one item per read command with the C value
// and the echoed row and column. Both use valid/ready, accepted when both high.
// Writes stream one item per cycle while in_ch.ready is high. A read presents its
// item on out_ch through the memory read register, then the output register;
// reads stream one per cycle as long as out_ch keeps taking items. A compute
// walks the A, B and C memories tile by tile, one multiply-accumulate per cycle
// through a three-stage operand read, multiply and accumulate plus
// read-modify-write pipe, so it holds in_ch.ready low until the walk is done and
// the pipe has drained; the first k tile's partial sum replaces its C entry and
// later ones add into it, forwarding when two writes in a row hit one entry.
// At reset the C memory reads as zero until the first compute (no clearing
// pass is needed); A and B hold nothing defined until written.
// When out_ch stalls, the finished item sits in the output register and one
// more read may sit in the memory read stage; further commands wait.
module tiled_int8_matrix_multiply_top (
  input  logic               clk,
  input  logic               rst_n,
  timm_cmd_if.sink           in_ch,
  timm_rsp_if.source         out_ch
);
  import timm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  localparam cnt_t T_C = CNT_W'(TILE_SIZE);
  localparam cnt_t N_C = CNT_W'(MATRIX_SIZE);

  state_t state_r, state_nxt;

  // tile origins and inner indices
  cnt_t r0_r, c0_r, k0_r, r_r, c_r, k_r;
  cnt_t r0_nxt, c0_nxt, k0_nxt, r_nxt, c_nxt, k_nxt;
  cnt_t rend, cend, kend;
  logic walk_done;

  // pipe stage tags
  logic  s1_valid_r, s1_first_r, s1_last_r, s1_clear_r;
  cell_t s1_cell_r;
  logic  s2_valid_r, s2_first_r, s2_last_r, s2_clear_r;
  cell_t s2_cell_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r, part_sum, c_base, c_wdata;
  logic              fwd_r;
  logic [ACC_W-1:0]  fwd_data_r;

  // read-back path
  logic       computed_r;
  logic       p1_valid_r, p1_zero_r;
  logic [3:0] p1_row_r, p1_col_r;
  logic       out_valid_r;
  logic [ACC_W-1:0] out_value_r;
  logic [3:0] out_row_r, out_col_r;
  logic       out_free, p1_stall;

  // memory ports
  logic              ab_inside, cmd_accept;
  command_t          cmd;
  cell_t             in_cell;
  logic              a_we, b_we, c_we, c_re, ab_re;
  cell_t             a_raddr, b_raddr, c_raddr;
  logic [ELEM_W-1:0] a_rdata, b_rdata;
  logic [ACC_W-1:0]  c_rdata;
  logic              issue;

  // command decode
  assign cmd        = command_t'(in_ch.command);
  assign ab_inside  = (int'(in_ch.row) < MATRIX_SIZE) && (int'(in_ch.col) < MATRIX_SIZE);
  assign in_cell    = cell_addr(int'(in_ch.row), int'(in_ch.col));
  assign out_free   = !out_valid_r || out_ch.ready;
  assign p1_stall   = p1_valid_r && !out_free;
  assign in_ch.ready = (state_r == S_IDLE) && !p1_stall;
  assign cmd_accept = in_ch.valid && in_ch.ready;

  // tile walk: k innermost, then c, r, then tiles k0, c0, r0
  assign rend = tile_end(r0_r);
  assign cend = tile_end(c0_r);
  assign kend = tile_end(k0_r);

  always_comb begin
    r0_nxt = r0_r;
    c0_nxt = c0_r;
    k0_nxt = k0_r;
    r_nxt  = r_r;
    c_nxt  = c_r;
    k_nxt  = k_r;
    walk_done = 1'b0;
    if (CNT_W'(k_r + 1'b1) != kend) begin
      k_nxt = CNT_W'(k_r + 1'b1);
    end else if (CNT_W'(c_r + 1'b1) != cend) begin
      k_nxt = k0_r;
      c_nxt = CNT_W'(c_r + 1'b1);
    end else if (CNT_W'(r_r + 1'b1) != rend) begin
      k_nxt = k0_r;
      c_nxt = c0_r;
      r_nxt = CNT_W'(r_r + 1'b1);
    end else begin
      if (CNT_W'(k0_r + T_C) < N_C) begin
        k0_nxt = CNT_W'(k0_r + T_C);
      end else begin
        k0_nxt = '0;
        if (CNT_W'(c0_r + T_C) < N_C) begin
          c0_nxt = CNT_W'(c0_r + T_C);
        end else begin
          c0_nxt = '0;
          if (CNT_W'(r0_r + T_C) < N_C) begin
            r0_nxt = CNT_W'(r0_r + T_C);
          end else begin
            r0_nxt = '0;
            walk_done = 1'b1;
          end
        end
      end
      r_nxt = r0_nxt;
      c_nxt = c0_nxt;
      k_nxt = k0_nxt;
    end
  end

  // operand memory access
  assign issue   = (state_r == S_RUN);
  assign a_we    = cmd_accept && (cmd == CMD_WRITE_A) && ab_inside;
  assign b_we    = cmd_accept && (cmd == CMD_WRITE_B) && ab_inside;
  assign ab_re   = issue;
  assign a_raddr = cell_addr(int'(r_r), int'(k_r));
  assign b_raddr = cell_addr(int'(k_r), int'(c_r));

  timm_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (in_cell),
    .wdata (in_ch.element_value),
    .re    (ab_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  timm_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_cell),
    .wdata (in_ch.element_value),
    .re    (ab_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // product memory: read-back in idle, old partial sums during compute
  assign c_re    = (cmd_accept && (cmd == CMD_READ_C)) || (s1_valid_r && s1_last_r);
  assign c_raddr = (state_r == S_IDLE) ? in_cell : s1_cell_r;

  // accumulate and write back, forwarding a same-entry write from last cycle
  assign part_sum = (s2_first_r ? '0 : acc_r) + ACC_W'(prod_r);
  assign c_base   = s2_clear_r ? '0 : (fwd_r ? fwd_data_r : c_rdata);
  assign c_wdata  = c_base + part_sum;
  assign c_we     = s2_valid_r && s2_last_r;

  timm_ram #(.WIDTH(ACC_W), .DEPTH(CELLS)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (s2_cell_r),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_accept && (cmd == CMD_COMPUTE)) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (walk_done) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_valid_r && !s2_valid_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and registered valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      r0_r        <= '0;
      c0_r        <= '0;
      k0_r        <= '0;
      r_r         <= '0;
      c_r         <= '0;
      k_r         <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      computed_r  <= 1'b0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (issue) begin
        r0_r <= r0_nxt;
        c0_r <= c0_nxt;
        k0_r <= k0_nxt;
        r_r  <= r_nxt;
        c_r  <= c_nxt;
        k_r  <= k_nxt;
      end
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
      fwd_r      <= s1_valid_r && s1_last_r && c_we && (s1_cell_r == s2_cell_r);
      if (cmd_accept && (cmd == CMD_COMPUTE)) begin
        computed_r <= 1'b1;
      end
      p1_valid_r <= (cmd_accept && (cmd == CMD_READ_C)) || p1_stall;
      if (p1_valid_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pipe payload
  always_ff @(posedge clk) begin
    s1_first_r <= (k_r == k0_r);
    s1_last_r  <= (CNT_W'(k_r + 1'b1) == kend);
    s1_clear_r <= (k0_r == '0);
    s1_cell_r  <= cell_addr(int'(r_r), int'(c_r));
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_clear_r <= s1_clear_r;
    s2_cell_r  <= s1_cell_r;
    prod_r     <= PROD_W'(a_rdata) * PROD_W'(b_rdata);
    if (s2_valid_r) begin
      acc_r <= part_sum;
    end
    fwd_data_r <= c_wdata;
  end

  // read-back payload
  always_ff @(posedge clk) begin
    if (cmd_accept && (cmd == CMD_READ_C)) begin
      p1_row_r  <= in_ch.row;
      p1_col_r  <= in_ch.col;
      p1_zero_r <= !ab_inside || !computed_r;
    end
    if (p1_valid_r && out_free) begin
      out_value_r <= p1_zero_r ? '0 : c_rdata;
      out_row_r   <= p1_row_r;
      out_col_r   <= p1_col_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.product_value = out_value_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the tiled int8 matrix multiply engine
`timescale 1ns / 100ps

module tb;
  import timm_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM    = 850;

  typedef struct {
    logic [ACC_W-1:0] value;
    logic [3:0]       row;
    logic [3:0]       col;
  } c_read_t;

  logic clk;
  logic rst_n;

  timm_cmd_if cmd_ch ();
  timm_rsp_if rsp_ch ();

  tiled_int8_matrix_multiply_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (rsp_ch)
  );

  // shadow copies of the A, B and C memories
  logic [ELEM_W-1:0] a_cells [CELLS];
  logic [ELEM_W-1:0] b_cells [CELLS];
  logic [ACC_W-1:0]  c_cells [CELLS];

  c_read_t expected_reads[$];
  int      mismatches;
  int      idle_cycles;
  bit      cmd_gaps;
  bit      rsp_gaps;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // full product of the shadow operands, sums wrap at 32 bits
  function automatic void multiply_stores();
    logic [ACC_W-1:0] acc;
    for (int r = 0; r < MATRIX_SIZE; r++) begin
      for (int c = 0; c < MATRIX_SIZE; c++) begin
        acc = '0;
        for (int k = 0; k < MATRIX_SIZE; k++) begin
          acc = acc + ACC_W'(a_cells[r * MATRIX_SIZE + k]) *
                      ACC_W'(b_cells[k * MATRIX_SIZE + c]);
        end
        c_cells[r * MATRIX_SIZE + c] = acc;
      end
    end
  endfunction

  // update the shadow state for one accepted command
  function automatic void apply_command(command_t cmd, int r, int c, int v);
    bit      in_range;
    int      idx;
    c_read_t rd;
    in_range = (r < MATRIX_SIZE) && (c < MATRIX_SIZE);
    idx      = in_range ? r * MATRIX_SIZE + c : 0;
    case (cmd)
      CMD_WRITE_A: begin
        if (in_range) a_cells[idx] = v[ELEM_W-1:0];
      end
      CMD_WRITE_B: begin
        if (in_range) b_cells[idx] = v[ELEM_W-1:0];
      end
      CMD_COMPUTE: begin
        multiply_stores();
      end
      default: begin
        rd.value = in_range ? c_cells[idx] : '0;
        rd.row   = r[3:0];
        rd.col   = c[3:0];
        expected_reads.push_back(rd);
      end
    endcase
  endfunction

  function automatic int rand_elem();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // drive one command item and wait for it to be taken
  task automatic send_cmd(command_t cmd, int r, int c, int v);
    int gap;
    gap = cmd_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      @(negedge clk);
      cmd_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_ch.valid         = 1'b1;
    cmd_ch.command       = cmd;
    cmd_ch.row           = r[3:0];
    cmd_ch.col           = c[3:0];
    cmd_ch.element_value = v[7:0];
    do @(posedge clk); while (!cmd_ch.ready);
    apply_command(cmd, r, c, v);
  endtask

  task automatic fill_operands(int a_val, int b_val);
    for (int r = 0; r < MATRIX_SIZE; r++) begin
      for (int c = 0; c < MATRIX_SIZE; c++) begin
        send_cmd(CMD_WRITE_A, r, c, a_val);
        send_cmd(CMD_WRITE_B, r, c, b_val);
      end
    end
  endtask

  // C reads as zero before any compute
  task automatic test_reads_after_reset();
    send_cmd(CMD_READ_C, 0, 0, 8'h00);
    send_cmd(CMD_READ_C, 15, 15, 8'hff);
    send_cmd(CMD_READ_C, 0, 15, 8'h00);
    send_cmd(CMD_READ_C, 15, 0, 8'hff);
  endtask

  // all operands at full scale gives the largest sums
  task automatic test_full_scale_product();
    fill_operands(255, 255);
    send_cmd(CMD_COMPUTE, 0, 0, 0);
    send_cmd(CMD_READ_C, 0, 0, 0);
    send_cmd(CMD_READ_C, 15, 15, 0);
    send_cmd(CMD_READ_C, 7, 8, 0);
    send_cmd(CMD_READ_C, 8, 7, 0);
  endtask

  // writes leave C alone until the next compute
  task automatic test_write_keeps_product();
    send_cmd(CMD_WRITE_A, 5, 5, 0);
    send_cmd(CMD_WRITE_B, 5, 5, 0);
    send_cmd(CMD_READ_C, 5, 5, 0);
    send_cmd(CMD_READ_C, 5, 6, 0);
  endtask

  // back-to-back computes must clear C, not accumulate into it
  task automatic test_compute_clears();
    for (int c = 0; c < MATRIX_SIZE; c++) send_cmd(CMD_WRITE_A, 0, c, 0);
    send_cmd(CMD_COMPUTE, 0, 0, 0);
    send_cmd(CMD_COMPUTE, 15, 15, 255);
    send_cmd(CMD_READ_C, 0, 3, 0);
    send_cmd(CMD_READ_C, 1, 3, 0);
    send_cmd(CMD_READ_C, 5, 5, 0);
    send_cmd(CMD_READ_C, 5, 9, 0);
  endtask

  // random mix of writes, read bursts and computes in chunks of idling modes
  task automatic test_random_traffic();
    int sent;
    int pick;
    int burst;
    sent = 0;
    while (sent < N_RANDOM) begin
      if (sent % 100 == 0) begin
        pick     = $urandom_range(0, 4);
        cmd_gaps = (pick == 1) || (pick >= 3);
        rsp_gaps = (pick == 2) || (pick >= 3);
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_cmd(CMD_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 255));
        sent++;
      end else if (pick < 30) begin
        send_cmd(CMD_WRITE_A, $urandom_range(0, 15), $urandom_range(0, 15), rand_elem());
        sent++;
      end else if (pick < 58) begin
        send_cmd(CMD_WRITE_B, $urandom_range(0, 15), $urandom_range(0, 15), rand_elem());
        sent++;
      end else if (pick < 70) begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          send_cmd(CMD_READ_C, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 255));
          sent++;
        end
      end else begin
        send_cmd(CMD_READ_C, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 255));
        sent++;
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // result sink with random back-pressure
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    forever begin
      gap = rsp_gaps ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        @(negedge clk);
        rsp_ch.ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!(rst_n && rsp_ch.valid));
    end
  end

  // compare each returned item with the oldest pending read
  always @(posedge clk) begin
    c_read_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected item value=%0d row=%0d col=%0d",
                                  rsp_ch.product_value, rsp_ch.out_row, rsp_ch.out_col));
      end else begin
        want = expected_reads.pop_front();
        if (rsp_ch.product_value !== want.value)
          report_mismatch($sformatf("product_value (%0d,%0d) expected %0d actual %0d",
                                    want.row, want.col, want.value, rsp_ch.product_value));
        if (rsp_ch.out_row !== want.row)
          report_mismatch($sformatf("out_row expected %0d actual %0d",
                                    want.row, rsp_ch.out_row));
        if (rsp_ch.out_col !== want.col)
          report_mismatch($sformatf("out_col expected %0d actual %0d",
                                    want.col, rsp_ch.out_col));
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tiled_int8_matrix_multiply_top regression: fail");
      $finish;
    end
  end

  // main sequence
  initial begin
    cmd_ch.valid         = 1'b0;
    cmd_ch.command       = CMD_WRITE_A;
    cmd_ch.row           = '0;
    cmd_ch.col           = '0;
    cmd_ch.element_value = '0;
    rst_n                = 1'b0;
    cmd_gaps             = 1'b1;
    rsp_gaps             = 1'b1;
    for (int i = 0; i < CELLS; i++) begin
      a_cells[i] = '0;
      b_cells[i] = '0;
      c_cells[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reads_after_reset();
    test_full_scale_product();
    test_write_keeps_product();
    test_compute_clears();
    test_random_traffic();

    // drain outstanding reads
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_reads.size() == 0) begin
      $display("tiled_int8_matrix_multiply_top regression: pass");
    end else begin
      $display("tiled_int8_matrix_multiply_top regression: fail");
    end
    $finish;
  end

endmodule
